### hdl/bounded_list_bank_defines.svh
// assertion macros for the list bank checker
`ifndef BOUNDED_LIST_BANK_DEFINES_SVH
`define BOUNDED_LIST_BANK_DEFINES_SVH
// implication checked on every clock edge out of reset
`define BLB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/blb_pkg.sv
// ----------------------------------------------------------------------------
// blb_pkg
// shared types and codes of the list bank
// ----------------------------------------------------------------------------
package blb_pkg;
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_PUSH   = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_SORTED = 3'd5;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_LIST  = 4'd1;
    localparam logic [3:0] ST_BAD_SIZE  = 4'd2;
    localparam logic [3:0] ST_EXISTS    = 4'd3;
    localparam logic [3:0] ST_NO_MEMORY = 4'd4;
    localparam logic [3:0] ST_FULL      = 4'd5;
    localparam logic [3:0] ST_NO_LIST   = 4'd6;
    localparam logic [3:0] ST_EMPTY     = 4'd7;
    localparam logic [3:0] ST_NOT_FOUND = 4'd8;

    // list table updates from the controller
    localparam logic [1:0] TBL_CREATE = 2'd0;
    localparam logic [1:0] TBL_INC    = 2'd1;
    localparam logic [1:0] TBL_DEC    = 2'd2;
    localparam logic [1:0] TBL_NONE   = 2'd3;
endpackage

### hdl/blb_ram.sv
// ----------------------------------------------------------------------------
// blb_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module blb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### hdl/blb_datapath.sv
// ----------------------------------------------------------------------------
// blb_datapath
// list table, entry store and walk buffer
// ----------------------------------------------------------------------------
module blb_datapath import blb_pkg::*; #(
    parameter int NUM_LISTS   = 10,
    parameter int MAX_DEPTH   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item capture
    input  logic                          load,
    input  logic [2:0]                    opcode,
    input  logic [3:0]                    list_number,
    input  logic [7:0]                    capacity,
    input  logic signed [VALUE_WIDTH-1:0] value,
    // control
    input  logic                          tbl_wr,       // commit table update
    input  logic [1:0]                    tbl_kind,     // kind of table update
    input  logic                          buf_wr,       // copy read data into buffer
    input  logic                          mem_wr_push,
    input  logic                          mem_wr_shift,
    input  logic                          idx_clr,
    input  logic                          idx_inc,
    input  logic                          idx_pos,      // index to last match
    input  logic                          match_clr,
    input  logic                          match_chk,
    input  logic                          sort_step,
    input  logic                          sort_clr,
    // status
    output logic [3:0]                    pre_status,  // status from checks
    output logic [$clog2(MAX_DEPTH+1)-1:0] fill,
    output logic [$clog2(MAX_DEPTH+1)-1:0] idx,
    output logic                          found,
    output logic                          sort_done,
    output logic [2:0]                    op,
    output logic signed [VALUE_WIDTH-1:0] buf_out
);
    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int DEPTH = NUM_LISTS * MAX_DEPTH;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [NUM_LISTS-1:0] exists_reg;
    logic [CW-1:0]        cap_reg  [NUM_LISTS];
    logic [CW-1:0]        fill_reg [NUM_LISTS];

    logic [2:0]                    op_reg;
    logic [3:0]                    num_reg;
    logic [7:0]                    capin_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic [CW-1:0]                 idx_reg;
    logic                          found_reg;
    logic [CW-1:0]                 pos_reg;
    logic [CW-1:0]                 sj_reg;     // sort inner index
    logic                          sdone_reg;
    logic signed [VALUE_WIDTH-1:0] buf_reg [MAX_DEPTH];

    logic [LW-1:0] li;
    logic          num_ok;
    logic [AW-1:0] base;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic          wr_en;
    logic [CW-1:0] cur_fill;
    logic [CW-1:0] cur_cap;

    assign num_ok   = (num_reg != 4'd0) && (32'(num_reg) <= NUM_LISTS);
    assign li       = num_ok ? LW'(num_reg - 4'd1) : '0;
    assign base     = AW'(32'(li) * MAX_DEPTH);
    assign cur_fill = fill_reg[li];
    assign cur_cap  = cap_reg[li];
    assign fill     = cur_fill;
    assign idx      = idx_reg;
    assign found    = found_reg;
    assign op       = op_reg;
    assign sort_done = sdone_reg;
    assign buf_out  = buf_reg[idx_reg[IW-1:0]];

    always_comb
    begin
        pre_status = ST_OK;
        if (!num_ok)
        begin
            pre_status = ST_BAD_LIST;
        end
        else if (op_reg == OP_CREATE)
        begin
            if (capin_reg == 8'd0)
                pre_status = ST_BAD_SIZE;
            else if (exists_reg[li])
                pre_status = ST_EXISTS;
            else if (32'(capin_reg) > MAX_DEPTH)
                pre_status = ST_NO_MEMORY;
        end
        else if (!exists_reg[li])
        begin
            pre_status = ST_NO_LIST;
        end
        else if (op_reg == OP_PUSH)
        begin
            if (cur_fill >= cur_cap)
                pre_status = ST_FULL;
        end
        else if ((op_reg == OP_POP) || (op_reg == OP_DELETE))
        begin
            if (cur_fill == '0)
                pre_status = ST_EMPTY;
        end
    end

    // memory port: shift writes entry idx with buffer entry idx+1
    assign rd_addr = base + AW'(idx_reg[IW-1:0]);
    assign wr_en   = mem_wr_push || mem_wr_shift;
    assign wr_addr = mem_wr_push ? base + AW'(cur_fill[IW-1:0]) : rd_addr;
    assign wr_data = mem_wr_push ? val_reg : buf_reg[IW'(idx_reg + 1'b1)];

    blb_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sort: one insertion step per cycle; sj walks down, idx marks outer index
    logic sgt;
    assign sgt = (sj_reg != '0) &&
                 (buf_reg[IW'(sj_reg - 1'b1)] > buf_reg[sj_reg[IW-1:0]]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                cap_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
            op_reg    <= '0;
            num_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            sj_reg    <= '0;
            sdone_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                op_reg  <= opcode;
                num_reg <= list_number;
            end
            if (tbl_wr)
            begin
                case (tbl_kind)
                    TBL_CREATE:
                    begin
                        exists_reg[li] <= 1'b1;
                        cap_reg[li]    <= CW'(capin_reg);
                        fill_reg[li]   <= '0;
                    end
                    TBL_INC: fill_reg[li] <= cur_fill + 1'b1;
                    TBL_DEC: fill_reg[li] <= cur_fill - 1'b1;
                    default: ;
                endcase
            end
            if (idx_clr)
                idx_reg <= '0;
            else if (idx_inc)
                idx_reg <= idx_reg + 1'b1;
            else if (idx_pos)
                idx_reg <= pos_reg;
            if (match_clr)
                found_reg <= 1'b0;
            else if (match_chk && (rd_data == val_reg))
                found_reg <= 1'b1;
            if (sort_clr)
            begin
                sj_reg    <= CW'(1);
                idx_reg   <= CW'(1);
                sdone_reg <= (cur_fill <= CW'(1));
            end
            else if (sort_step)
            begin
                if (sgt)
                begin
                    sj_reg <= sj_reg - 1'b1;
                end
                else if (idx_reg + 1'b1 >= cur_fill)
                begin
                    sdone_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                    sj_reg  <= idx_reg + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            capin_reg <= capacity;
            val_reg   <= value;
        end
        if (match_chk && (rd_data == val_reg))
            pos_reg <= idx_reg - 1'b1;
        if (buf_wr)
            buf_reg[IW'(idx_reg - 1'b1)] <= rd_data;
        if (sort_step && sgt)
        begin
            buf_reg[IW'(sj_reg - 1'b1)] <= buf_reg[sj_reg[IW-1:0]];
            buf_reg[sj_reg[IW-1:0]]     <= buf_reg[IW'(sj_reg - 1'b1)];
        end
    end
endmodule

### hdl/blb_ctrl.sv
// ----------------------------------------------------------------------------
// blb_ctrl
// command sequencer of the list bank
// ----------------------------------------------------------------------------
module blb_ctrl import blb_pkg::*; #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [3:0]                      status,
    output logic                            has_data,
    output logic                            last,
    output logic                            sel_data,
    input  logic [2:0]                      opcode,
    input  logic [3:0]                      pre_status,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]  fill,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]  idx,
    input  logic                            found,
    input  logic                            sort_done,
    input  logic [2:0]                      op,
    output logic                            load,
    output logic                            tbl_wr,
    output logic [1:0]                      tbl_kind,
    output logic                            buf_wr,
    output logic                            mem_wr_push,
    output logic                            mem_wr_shift,
    output logic                            idx_clr,
    output logic                            idx_inc,
    output logic                            idx_pos,
    output logic                            match_clr,
    output logic                            match_chk,
    output logic                            sort_step,
    output logic                            sort_clr
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_COPY, S_COPY_END, S_DEL_SHIFT, S_SORT, S_EMIT_IDX,
        S_EMIT, S_RESULT
    } state_t;

    state_t     state_reg;
    logic [3:0] status_reg;
    logic [3:0] res_reg;     // status of a single result not yet offered
    logic       has_reg;
    logic       last_reg;
    logic       valid_reg;

    logic accept;
    logic done_copy;
    logic out_free;
    logic fire;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign has_data  = has_reg;
    assign last      = last_reg;
    assign sel_data  = has_reg;

    assign accept    = in_valid && (state_reg == S_IDLE) && (opcode <= OP_SORTED);
    assign done_copy = (idx == fill);
    // output register empty or being taken this cycle
    assign out_free  = !valid_reg || !out_stall;
    assign fire      = ((state_reg == S_EMIT) || (state_reg == S_RESULT)) && out_free;

    always_comb
    begin
        load = accept;
        tbl_wr = 1'b0; tbl_kind = TBL_NONE; buf_wr = 1'b0;
        mem_wr_push = 1'b0; mem_wr_shift = 1'b0; idx_clr = 1'b0; idx_inc = 1'b0;
        idx_pos = 1'b0;
        match_clr = 1'b0; match_chk = 1'b0; sort_step = 1'b0; sort_clr = 1'b0;
        case (state_reg)
            S_CHECK:
            begin
                idx_clr = 1'b1;
                match_clr = 1'b1;
                if (pre_status == ST_OK)
                begin
                    case (op)
                        OP_CREATE:
                        begin
                            tbl_wr = 1'b1;
                            tbl_kind = TBL_CREATE;
                        end
                        OP_PUSH:
                        begin
                            tbl_wr = 1'b1;
                            tbl_kind = TBL_INC;
                            mem_wr_push = 1'b1;
                        end
                        OP_POP:
                        begin
                            tbl_wr = 1'b1;
                            tbl_kind = TBL_DEC;
                        end
                        default: ;
                    endcase
                end
            end
            S_COPY:
            begin
                // read data of index idx-1 arrives now
                idx_inc = !done_copy;
                if (idx != '0)
                begin
                    buf_wr = 1'b1;
                    match_chk = 1'b1;
                end
            end
            S_COPY_END:
            begin
                idx_clr = (op != OP_SORTED) && (op != OP_DELETE);
                sort_clr = (op == OP_SORTED);
                // shift starts at the last match
                idx_pos = (op == OP_DELETE) && found;
            end
            S_DEL_SHIFT:
            begin
                if (idx + 1'b1 < fill)
                begin
                    mem_wr_shift = 1'b1;
                    idx_inc = 1'b1;
                end
                else
                begin
                    tbl_wr = 1'b1;
                    tbl_kind = TBL_DEC;
                end
            end
            S_SORT:
            begin
                if (!sort_done)
                    sort_step = 1'b1;
                else
                    idx_clr = 1'b1;
            end
            S_EMIT:
            begin
                idx_inc = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= 1'b0;
            status_reg <= '0;
            res_reg    <= ST_OK;
            has_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
                valid_reg <= 1'b1;
            else if (valid_reg && !out_stall)
                valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if ((pre_status != ST_OK) || (op <= OP_POP) ||
                        ((op != OP_DELETE) && (fill == '0)))
                    begin
                        res_reg   <= pre_status;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_COPY;
                    end
                end
                S_COPY:
                begin
                    if (done_copy)
                        state_reg <= S_COPY_END;
                end
                S_COPY_END:
                begin
                    if (op == OP_DELETE)
                    begin
                        if (!found)
                        begin
                            res_reg   <= ST_NOT_FOUND;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            state_reg <= S_DEL_SHIFT;
                        end
                    end
                    else if (op == OP_SORTED)
                        state_reg <= S_SORT;
                    else
                        state_reg <= S_EMIT;
                end
                S_DEL_SHIFT:
                begin
                    if (!(idx + 1'b1 < fill))
                    begin
                        res_reg   <= ST_OK;
                        state_reg <= S_RESULT;
                    end
                end
                S_SORT:
                begin
                    if (sort_done)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (fire)
                    begin
                        status_reg <= ST_OK;
                        has_reg    <= 1'b1;
                        last_reg   <= (idx + 1'b1 == fill);
                        if (idx + 1'b1 == fill)
                            state_reg <= S_EMIT_IDX;
                    end
                end
                S_EMIT_IDX:
                begin
                    // last entry handed over; wait for it to leave
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                S_RESULT:
                begin
                    if (fire)
                    begin
                        status_reg <= res_reg;
                        has_reg    <= 1'b0;
                        last_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/bounded_list_bank.sv
// ----------------------------------------------------------------------------
// bounded_list_bank
// bank of numbered bounded lists with create, push, pop, delete and reads
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  input   | opcode list_number capacity value         | in_valid / in_stall
//  output  | status has_data data_value last           | out_valid / out_stall
//
//  create, push and pop hold the input through the check, then until the result is offered
//  delete and the reads copy the list out of the ram, one entry a cycle
//  sorted read adds one compare/swap a cycle
//  reset clears list table and control registers, not the entry ram; entry ram needs no clearing pass
//  a stalled output item holds; a single result may wait while the next item runs
module bounded_list_bank import blb_pkg::*; #(
    parameter int NUM_LISTS   = 10,
    parameter int MAX_DEPTH   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    opcode,
    input  logic [3:0]                    list_number,
    input  logic [7:0]                    capacity,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    status,
    output logic                          has_data,
    output logic signed [VALUE_WIDTH-1:0] data_value,
    output logic                          last
);
    localparam int CW = $clog2(MAX_DEPTH + 1);

    logic load, tbl_wr, buf_wr, mem_wr_push, mem_wr_shift;
    logic idx_clr, idx_inc, idx_pos, match_clr, match_chk, sort_step, sort_clr;
    logic [1:0] tbl_kind;
    logic [3:0] pre_status;
    logic [CW-1:0] fill, idx;
    logic found, sort_done, sel_data;
    logic [2:0] op;
    logic signed [VALUE_WIDTH-1:0] buf_out;
    logic signed [VALUE_WIDTH-1:0] data_reg;

    blb_ctrl #(.MAX_DEPTH(MAX_DEPTH)) u_ctrl (.*);

    blb_datapath #(
        .NUM_LISTS(NUM_LISTS), .MAX_DEPTH(MAX_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (.*);

    // output data captured alongside the emitted entry
    always_ff @(posedge clk)
    begin
        if (idx_inc && !mem_wr_shift && !buf_wr)
            data_reg <= buf_out;
    end
    assign data_value = sel_data ? data_reg : '0;
endmodule

### hdl/blb_checker.sv
// ----------------------------------------------------------------------------
// blb_checker
// port-level checks of the list bank
// ----------------------------------------------------------------------------
`include "bounded_list_bank_defines.svh"
module blb_checker import blb_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] status,
    input logic       has_data,
    input logic       last
);
    `BLB_ASSERT_IMP(a_data_ok, clk, rst_n, out_valid && has_data, status == ST_OK)
    `BLB_ASSERT_IMP(a_nodata_last, clk, rst_n, out_valid && !has_data, last)
    `BLB_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status))
endmodule

bind bounded_list_bank blb_checker u_chk (.*);

### tb/bounded_list_bank_checker.sv
// ----------------------------------------------------------------------------
// bounded_list_bank_checker
// watches both channels, predicts the list bank results and compares them
// ----------------------------------------------------------------------------
module bounded_list_bank_checker import blb_pkg::*; #(
    parameter int NUM_LISTS   = 10,
    parameter int MAX_DEPTH   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [2:0]                    opcode,
    input  logic [3:0]                    list_number,
    input  logic [7:0]                    capacity,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [3:0]                    status,
    input  logic                          has_data,
    input  logic signed [VALUE_WIDTH-1:0] data_value,
    input  logic                          last,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]                    st;
        logic                          hd;
        logic signed [VALUE_WIDTH-1:0] dv;
        logic                          lst;
    } answer_t;

    answer_t answer_q[$];

    logic                          live[NUM_LISTS];
    int                            cap_of[NUM_LISTS];
    int                            fill_of[NUM_LISTS];
    logic signed [VALUE_WIDTH-1:0] cells[NUM_LISTS][MAX_DEPTH];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic answer_t mk(logic [3:0] s, logic h, logic signed [VALUE_WIDTH-1:0] d,
                                   logic l);
        answer_t a;
        a.st = s; a.hd = h; a.dv = d; a.lst = l;
        return a;
    endfunction

    // single result carrying only a status
    function automatic answer_t plain(logic [3:0] s);
        return mk(s, 1'b0, '0, 1'b1);
    endfunction

    task automatic predict_command(input logic [2:0] op, input logic [3:0] num,
                                   input logic [7:0] cp, input logic signed [VALUE_WIDTH-1:0] v);
        int li;
        int f;
        int pos;
        logic signed [VALUE_WIDTH-1:0] buf_v[MAX_DEPTH];
        logic signed [VALUE_WIDTH-1:0] key;
        int j;
        if (op > OP_SORTED)
            return;
        if (num < 1 || num > NUM_LISTS) begin
            answer_q.push_back(plain(ST_BAD_LIST));
            return;
        end
        li = int'(num) - 1;
        if (op == OP_CREATE) begin
            if (cp == 0) answer_q.push_back(plain(ST_BAD_SIZE));
            else if (live[li]) answer_q.push_back(plain(ST_EXISTS));
            else if (cp > MAX_DEPTH) answer_q.push_back(plain(ST_NO_MEMORY));
            else
            begin
                live[li] = 1'b1; cap_of[li] = int'(cp); fill_of[li] = 0;
                answer_q.push_back(plain(ST_OK));
            end
            return;
        end
        if (!live[li]) begin
            answer_q.push_back(plain(ST_NO_LIST));
            return;
        end
        f = fill_of[li];
        case (op)
            OP_PUSH:
                if (f >= cap_of[li]) answer_q.push_back(plain(ST_FULL));
                else
                begin
                    cells[li][f] = v; fill_of[li] = f + 1;
                    answer_q.push_back(plain(ST_OK));
                end
            OP_POP:
                if (f == 0) answer_q.push_back(plain(ST_EMPTY));
                else
                begin
                    fill_of[li] = f - 1;
                    answer_q.push_back(plain(ST_OK));
                end
            OP_DELETE:
                if (f == 0) answer_q.push_back(plain(ST_EMPTY));
                else
                begin
                    pos = -1;
                    for (int i = 0; i < f; i++)
                        if (cells[li][i] == v) pos = i;
                    if (pos < 0) answer_q.push_back(plain(ST_NOT_FOUND));
                    else
                    begin
                        // later entries close the gap
                        for (int i = pos; i + 1 < f; i++) cells[li][i] = cells[li][i+1];
                        fill_of[li] = f - 1;
                        answer_q.push_back(plain(ST_OK));
                    end
                end
            default:
                if (f == 0) answer_q.push_back(plain(ST_OK));
                else
                begin
                    for (int i = 0; i < f; i++) buf_v[i] = cells[li][i];
                    if (op == OP_SORTED)
                        for (int i = 1; i < f; i++) begin
                            key = buf_v[i];
                            j = i;
                            while (j > 0 && buf_v[j-1] > key) begin
                                buf_v[j] = buf_v[j-1];
                                j--;
                            end
                            buf_v[j] = key;
                        end
                    for (int i = 0; i < f; i++)
                        answer_q.push_back(mk(ST_OK, 1'b1, buf_v[i], i + 1 == f));
                end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        answer_t exp_a;
        if (!rst_n) begin
            fail_count = 0;
            answer_q.delete();
            for (int i = 0; i < NUM_LISTS; i++) begin
                live[i] = 1'b0; cap_of[i] = 0; fill_of[i] = 0;
            end
        end
        else
        begin
            if (out_valid && !out_stall) begin
                if (answer_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    exp_a = answer_q.pop_front();
                    if (status !== exp_a.st)
                        report($sformatf("status %0d, expected %0d", status, exp_a.st));
                    if (has_data !== exp_a.hd)
                        report($sformatf("has_data %0b, expected %0b", has_data, exp_a.hd));
                    if (data_value !== exp_a.dv)
                        report($sformatf("data_value %0d, expected %0d", data_value, exp_a.dv));
                    if (last !== exp_a.lst)
                        report($sformatf("last %0b, expected %0b", last, exp_a.lst));
                end
            end
            if (in_valid && !in_stall)
                predict_command(opcode, list_number, capacity, value);
        end
        pending = answer_q.size();
    end
endmodule

### tb/bounded_list_bank_test.sv
// ----------------------------------------------------------------------------
// bounded_list_bank_test
// directed and random list commands against the list bank, with random gaps
// ----------------------------------------------------------------------------
module bounded_list_bank_test import blb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NL = 10;
    localparam int MD = 16;
    localparam int VW = 32;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [2:0]    opcode;
    logic [3:0]    list_number;
    logic [7:0]    capacity;
    logic signed [VW-1:0] value;
    logic          out_valid;
    logic          out_stall;
    logic [3:0]    status;
    logic          has_data;
    logic signed [VW-1:0] data_value;
    logic          last;
    int            fail_count;
    int            pending;

    // values recently pushed, so deletes often hit
    logic signed [VW-1:0] seen_values[$];

    bounded_list_bank #(.NUM_LISTS(NL), .MAX_DEPTH(MD), .VALUE_WIDTH(VW)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .list_number(list_number), .capacity(capacity), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .has_data(has_data), .data_value(data_value), .last(last)
    );

    bounded_list_bank_checker #(.NUM_LISTS(NL), .MAX_DEPTH(MD), .VALUE_WIDTH(VW)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .list_number(list_number), .capacity(capacity), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .has_data(has_data), .data_value(data_value), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver side: random stall, with stall-free stretches
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            n = $urandom_range(0, 3) == 0 ? 0 : gap_len();
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one item: hold valid until accepted, then an optional gap
    task automatic send_item(input logic [2:0] op, input logic [3:0] num,
                             input logic [7:0] cp, input logic signed [VW-1:0] v);
        int g;
        in_valid    <= 1'b1;
        opcode      <= op;
        list_number <= num;
        capacity    <= cp;
        value       <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (op == OP_PUSH) seen_values.push_back(v);
        if (seen_values.size() > 40) void'(seen_values.pop_front());
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic signed [VW-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(VW-1){1'b0}}};
            1: return {1'b0, {(VW-1){1'b1}}};
            2: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        logic [3:0] num;
        logic [7:0] cp;
        logic signed [VW-1:0] v;
        int r;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_CREATE;
        list_number = 4'd0;
        capacity    = 8'd0;
        value       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: check order and every status
        send_item(OP_CREATE, 4'd0, 8'd4, 0);          // bad list, low
        send_item(OP_PUSH, 4'd15, 8'd0, 0);           // bad list, high
        send_item(OP_CREATE, 4'd1, 8'd0, 0);          // bad size
        send_item(OP_CREATE, 4'd1, 8'd17, 0);         // no memory
        send_item(OP_CREATE, 4'd2, 8'd255, 0);        // no memory, capacity all ones
        send_item(OP_PUSH, 4'd1, 8'd0, 5);            // no list
        send_item(OP_READ, 4'd1, 8'd0, 0);            // read fails on no list
        send_item(OP_CREATE, 4'd1, 8'd2, 0);
        send_item(OP_CREATE, 4'd1, 8'd2, 0);          // exists
        send_item(OP_CREATE, 4'd1, 8'd0, 0);          // bad size beats exists
        send_item(OP_READ, 4'd1, 8'd0, 0);            // empty read
        send_item(OP_POP, 4'd1, 8'd0, 0);             // empty pop
        send_item(OP_DELETE, 4'd1, 8'd0, 0);          // empty delete
        send_item(OP_PUSH, 4'd1, 8'd0, {1'b0, {(VW-1){1'b1}}});
        send_item(OP_PUSH, 4'd1, 8'd0, {1'b1, {(VW-1){1'b0}}});
        send_item(OP_PUSH, 4'd1, 8'd0, 1);            // full
        send_item(OP_SORTED, 4'd1, 8'd0, 0);
        send_item(OP_DELETE, 4'd1, 8'd0, 7);          // not found
        send_item(3'd6, 4'd1, 8'd0, 0);               // ignored opcodes
        send_item(3'd7, 4'd1, 8'd0, 0);
        send_item(OP_CREATE, 4'd10, 8'd16, 0);        // top list, full depth
        for (int i = 0; i < 16; i++) send_item(OP_PUSH, 4'd10, 8'd0, (i % 3) - 1);
        send_item(OP_DELETE, 4'd10, 8'd0, 0);         // last occurrence of a repeat
        send_item(OP_SORTED, 4'd10, 8'd0, 0);
        send_item(OP_READ, 4'd10, 8'd0, 0);

        // random: mostly valid lists that get created and filled
        for (int k = 0; k < 130; k++) begin
            r   = $urandom_range(0, 99);
            num = (r < 90) ? 4'($urandom_range(1, NL)) : 4'($urandom);
            cp  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, MD)) : 8'($urandom);
            v   = rand_value();
            r   = $urandom_range(0, 99);
            if (r < 10) op = OP_CREATE;
            else if (r < 50) op = OP_PUSH;
            else if (r < 60) op = OP_POP;
            else if (r < 75)
            begin
                op = OP_DELETE;
                if (seen_values.size() > 0 && $urandom_range(0, 3) != 0)
                    v = seen_values[$urandom_range(0, seen_values.size() - 1)];
            end
            else if (r < 85) op = OP_READ;
            else if (r < 96) op = OP_SORTED;
            else op = 3'($urandom_range(6, 7));
            send_item(op, num, cp, v);
        end
        in_valid <= 1'b0;
        // let the checker take in the last item
        @(posedge clk);

        // drain, then let the block settle
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
